// ----- design/hue_color_to_rgb_convert_core_assert.svh -----
// Assertion macros shared by the hue color converter RTL.
// Needs nothing else; include by bare file name.
`ifndef HUE_COLOR_TO_RGB_CONVERT_CORE_ASSERT_SVH
`define HUE_COLOR_TO_RGB_CONVERT_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define HCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define HCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/hcr_pkg.sv -----
// Package for the hue color converter: fixed-point constants and shared types.
// Depends on nothing.
`timescale 1ns / 1ps

package hcr_pkg;

   typedef enum logic {
      MODEL_HSL = 1'b0,
      MODEL_HWB = 1'b1
   } model_type;

   localparam int unsigned HUE_TURN  = 23040;   // 360 degrees in 1/64 degree
   localparam int unsigned PCT_FULL  = 12800;   // 100 % in 1/128 %
   localparam int unsigned K_SCALE   = 1920;    // one twelfth-turn step
   localparam int unsigned CH_MAX    = 65280;   // 255.0 in 8.8
   localparam int unsigned ALPHA_MAX = 1024;

   localparam int unsigned DEPTH     = 10;      // register stages
   localparam int unsigned DIV_STEPS = 8;       // divider stages, two bits each

   // HSL base term L * 12800 * 1920
   localparam logic [24:0] L_GAIN    = 25'd24576000;
   // half of 625 * 2^17, rounding offset before the final divide
   localparam logic [45:0] RND_HALF  = 46'd40960000;
   // ceil(2^36 / 625), exact for a 26-bit dividend
   localparam logic [26:0] RECIP_625 = 27'd109951163;

   typedef logic [15:0] chan_type;

   // channel hue offsets 0, 8 and 4 twelfths, in 1/1920 units
   function automatic logic [15:0] hue_offset(input logic [1:0] idx);
      logic [15:0] r;
      begin
         case (idx)
            2'd0:    r = 16'd0;
            2'd1:    r = 16'd15360;
            2'd2:    r = 16'd7680;
            default: r = 16'd0;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- design/hue_color_to_rgb_convert_core.sv -----
// Top level of the HSL / HWB to RGB converter, ten-stage pipeline.
// Uses hcr_pkg and hue_color_to_rgb_convert_core_assert.svh.
`timescale 1ns / 1ps
//
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------------------
//  req     | req_tvalid/tready/tdata/tuser  | tuser: cmd; tdata: hue, first_pct,
//          |                                |   second_pct, alpha_in
//  rsp     | rsp_tvalid/tready/tdata        | tdata: red, green, blue, alpha_out
//
//  One transaction per clock sustained while the output is not stalled. The
//  gray-level divider (16 quotient bits, two per stage) runs beside the
//  multiplier path. Each stage holds its own valid bit and advances when the
//  stage ahead is empty or moving, so a stalled output still lets bubbles
//  fill. Synchronous reset clears the valid bits only.

module hue_color_to_rgb_convert_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // hue[15:0], first_pct[31:16], second_pct[47:32],
                                    // alpha_in[59:48], zero[63:60]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // red[15:0], green[31:16], blue[47:32],
                                    // alpha_out[58:48], zero[63:59]
);

   localparam int unsigned D = hcr_pkg::DEPTH;

   // stage control
   logic [D-1:0] v_ff;
   logic [D-1:0] adv;

   // carried along every stage
   logic [10:0] al_ff   [D];
   logic        cmd_ff  [D];
   logic        gray_ff [D];

   // stage 0: clamped inputs, wrapped hue
   logic [14:0] h0_ff;
   logic [13:0] p1_0_ff, p2_0_ff;
   // stage 1: hue terms, S*M, HWB scale
   logic signed [11:0] f1_ff [3];
   logic [26:0] sm1_ff;
   logic [13:0] p1_1_ff, p2_1_ff, sc1_ff;
   // stage 2: products
   logic signed [39:0] prod2_ff [3];
   logic [38:0] base2_ff;
   logic [25:0] t2_ff [3];
   logic [25:0] w2_ff;
   // stage 3: reduced dividend
   logic [25:0] y3_ff [3];
   logic        pos3_ff [3];
   // stage 4: reciprocal product
   logic [16:0] q4_ff [3];
   logic        pos4_ff [3];
   // stages 5..8: finished channel values
   hcr_pkg::chan_type ch_ff [D][3];
   // divider: remainder, shifting dividend/quotient, divisor
   logic [14:0] rem_ff [D];
   logic [15:0] lo_ff  [D];
   logic [14:0] dv_ff  [D];

   // output stage
   hcr_pkg::chan_type out_ff [3];

   // --- handshake -------------------------------------------------------
   always_comb begin
      adv[D-1] = ~v_ff[D-1] | rsp_tready;
      for (int i = D - 2; i >= 0; i--) begin
         adv[i] = ~v_ff[i] | adv[i+1];
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[D-1];
   assign rsp_tdata  = {5'd0, al_ff[D-1], out_ff[2], out_ff[1], out_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < D; i++) begin
            if (adv[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // --- stage 0: clamp and wrap -----------------------------------------
   logic signed [15:0] hue_s, p1_s, p2_s;
   logic signed [11:0] al_s;
   logic [17:0] hsum;
   logic [14:0] h0_in;
   logic [13:0] p1_0_in, p2_0_in;
   logic [10:0] al0_in;

   always_comb begin
      hue_s = signed'(req_tdata[15:0]);
      p1_s  = signed'(req_tdata[31:16]);
      p2_s  = signed'(req_tdata[47:32]);
      al_s  = signed'(req_tdata[59:48]);
      hsum  = 18'(signed'({{2{hue_s[15]}}, hue_s}) + 18'sd46080);
      if (hsum >= 18'd69120) begin
         h0_in = 15'(hsum - 18'd69120);
      end else if (hsum >= 18'd46080) begin
         h0_in = 15'(hsum - 18'd46080);
      end else if (hsum >= 18'd23040) begin
         h0_in = 15'(hsum - 18'd23040);
      end else begin
         h0_in = 15'(hsum);
      end
      if (p1_s < 0) begin
         p1_0_in = '0;
      end else if (p1_s > 16'sd12800) begin
         p1_0_in = 14'(hcr_pkg::PCT_FULL);
      end else begin
         p1_0_in = p1_s[13:0];
      end
      if (p2_s < 0) begin
         p2_0_in = '0;
      end else if (p2_s > 16'sd12800) begin
         p2_0_in = 14'(hcr_pkg::PCT_FULL);
      end else begin
         p2_0_in = p2_s[13:0];
      end
      if (al_s < 0) begin
         al0_in = '0;
      end else if (al_s > 12'sd1024) begin
         al0_in = 11'(hcr_pkg::ALPHA_MAX);
      end else begin
         al0_in = al_s[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         h0_ff      <= h0_in;
         p1_0_ff    <= p1_0_in;
         p2_0_ff    <= p2_0_in;
         al_ff[0]   <= al0_in;
         cmd_ff[0]  <= req_tuser;
         gray_ff[0] <= 1'b0;
      end
   end

   // --- stage 1: hue terms, S*M, divider setup --------------------------
   logic signed [11:0] f1_in [3];
   logic [12:0] m1;
   logic [14:0] wb_sum;
   logic        gray1_in;
   logic [29:0] gnum;

   always_comb begin
      logic [15:0] kr;
      logic [14:0] k;
      logic signed [16:0] a, b, f;
      for (int i = 0; i < 3; i++) begin
         kr = 16'(h0_ff) + hcr_pkg::hue_offset(2'(i));
         k  = (kr >= 16'd23040) ? 15'(kr - 16'd23040) : kr[14:0];
         a  = signed'({2'b00, k}) - 17'sd5760;
         b  = 17'sd17280 - signed'({2'b00, k});
         f  = (a < b) ? a : b;
         if (f < -17'sd1920) begin
            f1_in[i] = -12'sd1920;
         end else if (f > 17'sd1920) begin
            f1_in[i] = 12'sd1920;
         end else begin
            f1_in[i] = f[11:0];
         end
      end
      m1 = (p2_0_ff < 14'd6400) ? p2_0_ff[12:0] : 13'(14'd12800 - p2_0_ff);
      wb_sum   = 15'(p1_0_ff) + 15'(p2_0_ff);
      gray1_in = (cmd_ff[0] == hcr_pkg::MODEL_HWB) && (wb_sum >= 15'd12800);
      // 65280*W + floor((W+B)/2)
      gnum = 30'(p1_0_ff) * 30'(hcr_pkg::CH_MAX) + 30'(wb_sum[14:1]);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int i = 0; i < 3; i++) begin
            f1_ff[i] <= f1_in[i];
         end
         sm1_ff     <= 27'(p1_0_ff) * 27'(m1);
         p1_1_ff    <= p1_0_ff;
         p2_1_ff    <= p2_0_ff;
         sc1_ff     <= gray1_in ? 14'd0 : 14'(15'd12800 - wb_sum);
         al_ff[1]   <= al_ff[0];
         cmd_ff[1]  <= cmd_ff[0];
         gray_ff[1] <= gray1_in;
         rem_ff[1]  <= 15'(gnum[29:16]);
         lo_ff[1]   <= gnum[15:0];
         dv_ff[1]   <= wb_sum;
      end
   end

   // --- stage 2: products -----------------------------------------------
   always_ff @(posedge clock) begin
      logic [11:0] omf;
      if (adv[2]) begin
         for (int i = 0; i < 3; i++) begin
            prod2_ff[i] <= 40'(signed'({1'b0, sm1_ff})) * 40'(f1_ff[i]);
            omf          = 12'(13'sd1920 - 13'(f1_ff[i]));
            t2_ff[i]    <= 26'(omf) * 26'(sc1_ff);
         end
         base2_ff   <= 39'(p2_1_ff) * 39'(hcr_pkg::L_GAIN);
         w2_ff      <= 26'(p1_1_ff) * 26'd3840;
         al_ff[2]   <= al_ff[1];
         cmd_ff[2]  <= cmd_ff[1];
         gray_ff[2] <= gray_ff[1];
      end
   end

   // --- stage 3: numerator, scale by 17, round, drop 2^17 ---------------
   logic [25:0] y3_in   [3];
   logic        pos3_in [3];

   always_comb begin
      logic signed [40:0] n;
      logic [26:0] s;
      logic signed [45:0] x;
      for (int i = 0; i < 3; i++) begin
         s = 27'(t2_ff[i]) + 27'(w2_ff);
         if (cmd_ff[2] == hcr_pkg::MODEL_HSL) begin
            n = signed'({2'b00, base2_ff}) - 41'(prod2_ff[i]);
         end else begin
            // times 6400 brings HWB onto the HSL denominator
            n = signed'({2'b00, 39'({s, 12'd0}) + 39'({s, 11'd0}) + 39'({s, 8'd0})});
         end
         x = signed'({n, 4'd0}) + 46'(n) + signed'(hcr_pkg::RND_HALF);
         pos3_in[i] = (n > 0);
         y3_in[i]   = x[42:17];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int i = 0; i < 3; i++) begin
            y3_ff[i]   <= y3_in[i];
            pos3_ff[i] <= pos3_in[i];
         end
         al_ff[3]   <= al_ff[2];
         cmd_ff[3]  <= cmd_ff[2];
         gray_ff[3] <= gray_ff[2];
      end
   end

   // --- stage 4: divide by 625 through the reciprocal -------------------
   always_ff @(posedge clock) begin
      logic [52:0] pr;
      if (adv[4]) begin
         for (int i = 0; i < 3; i++) begin
            pr          = 53'(y3_ff[i]) * 53'(hcr_pkg::RECIP_625);
            q4_ff[i]   <= pr[52:36];
            pos4_ff[i] <= pos3_ff[i];
         end
         al_ff[4]   <= al_ff[3];
         cmd_ff[4]  <= cmd_ff[3];
         gray_ff[4] <= gray_ff[3];
      end
   end

   // --- stage 5: clamp; stages 6..8 carry -------------------------------
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int i = 0; i < 3; i++) begin
            if (!pos4_ff[i]) begin
               ch_ff[5][i] <= '0;
            end else if (q4_ff[i] > 17'(hcr_pkg::CH_MAX)) begin
               ch_ff[5][i] <= 16'(hcr_pkg::CH_MAX);
            end else begin
               ch_ff[5][i] <= q4_ff[i][15:0];
            end
         end
         al_ff[5]   <= al_ff[4];
         cmd_ff[5]  <= cmd_ff[4];
         gray_ff[5] <= gray_ff[4];
      end
   end

   for (genvar s = 6; s < D - 1; s++) begin : g_carry
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            ch_ff[s]   <= ch_ff[s-1];
            al_ff[s]   <= al_ff[s-1];
            cmd_ff[s]  <= cmd_ff[s-1];
            gray_ff[s] <= gray_ff[s-1];
         end
      end
   end

   // --- gray divider: two restoring steps per stage, stages 2..9 --------
   logic [14:0] rem_in [D];
   logic [15:0] lo_in  [D];

   always_comb begin
      logic [15:0] r2;
      logic [14:0] r;
      logic [15:0] l;
      for (int s = 0; s < D; s++) begin
         rem_in[s] = '0;
         lo_in[s]  = '0;
      end
      for (int s = 2; s < D; s++) begin
         r = rem_ff[s-1];
         l = lo_ff[s-1];
         for (int j = 0; j < 2; j++) begin
            r2 = {r, l[15]};
            if (r2 >= 16'(dv_ff[s-1])) begin
               r = 15'(r2 - 16'(dv_ff[s-1]));
               l = {l[14:0], 1'b1};
            end else begin
               r = r2[14:0];
               l = {l[14:0], 1'b0};
            end
         end
         rem_in[s] = r;
         lo_in[s]  = l;
      end
   end

   // stage 9 takes its last two quotient bits straight from lo_in
   for (genvar s = 2; s < D - 1; s++) begin : g_div
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s] <= rem_in[s];
            lo_ff[s]  <= lo_in[s];
            dv_ff[s]  <= dv_ff[s-1];
         end
      end
   end

   // --- stage 9: pick gray or color -------------------------------------
   always_ff @(posedge clock) begin
      if (adv[D-1]) begin
         for (int i = 0; i < 3; i++) begin
            out_ff[i] <= gray_ff[D-2] ? lo_in[D-1] : ch_ff[D-2][i];
         end
         al_ff[D-1]   <= al_ff[D-2];
         cmd_ff[D-1]  <= cmd_ff[D-2];
         gray_ff[D-1] <= gray_ff[D-2];
      end
   end

   // --- checks ----------------------------------------------------------
`include "hue_color_to_rgb_convert_core_assert.svh"

   `HCR_ASSERT_NEXT(a_accept_fills, clock, reset, req_tvalid && req_tready, v_ff[0])
   `HCR_ASSERT_NOW(a_gray_equal, clock, reset, rsp_tvalid && gray_ff[D-1], out_ff[0] == out_ff[1] && out_ff[1] == out_ff[2])
   `HCR_ASSERT_NOW(a_gray_hwb, clock, reset, rsp_tvalid && gray_ff[D-1], cmd_ff[D-1] == hcr_pkg::MODEL_HWB)
   `HCR_ASSERT_NOW(a_range, clock, reset, rsp_tvalid, rsp_tdata[15:0] <= 16'd65280 && rsp_tdata[58:48] <= 11'd1024)

endmodule
